// ----- hw/rtl/ntls_pkg.sv -----
`default_nettype none

package ntls_pkg;

   // Default width of the frame counter.
   localparam int FRAME_INDEX_BITS_DEFAULT = 16;

   // Field widths.
   localparam int BYTE_BITS  = 8;
   localparam int WORD_BITS  = 8;
   localparam int ROW_BITS   = 16;
   localparam int FNUM_BITS  = 16;
   localparam int EVENT_BITS = 2;

   // Saturation limits.
   localparam logic [WORD_BITS-1:0] WORD_MAX = {WORD_BITS{1'b1}};
   localparam logic [ROW_BITS-1:0]  ROW_MAX  = {ROW_BITS{1'b1}};

   // Characters that matter to the scanner.
   localparam logic [BYTE_BITS-1:0] CHAR_MINUS   = 8'h2D;
   localparam logic [BYTE_BITS-1:0] CHAR_PLUS    = 8'h2B;
   localparam logic [BYTE_BITS-1:0] CHAR_POINT   = 8'h2E;
   localparam logic [BYTE_BITS-1:0] CHAR_LOWER_E = 8'h65;
   localparam logic [BYTE_BITS-1:0] CHAR_UPPER_E = 8'h45;
   localparam logic [BYTE_BITS-1:0] CHAR_ZERO    = 8'h30;
   localparam logic [BYTE_BITS-1:0] CHAR_NINE    = 8'h39;
   localparam logic [BYTE_BITS-1:0] CHAR_BS      = 8'd8;
   localparam logic [BYTE_BITS-1:0] CHAR_CR      = 8'd13;
   localparam logic [BYTE_BITS-1:0] CHAR_SPACE   = 8'h20;
   localparam logic [BYTE_BITS-1:0] CHAR_NEWLINE = 8'h0A;

   // Frame event codes.
   typedef enum logic [EVENT_BITS-1:0] {
      EVENT_NONE     = 2'd0,
      EVENT_TITLED   = 2'd1,
      EVENT_UNTITLED = 2'd2
   } frame_event_type;

   // Character classes.
   typedef enum logic [1:0] {
      CLASS_OTHER   = 2'd0,
      CLASS_NUMERIC = 2'd1,
      CLASS_WHITE   = 2'd2
   } char_class_type;

   // Summary of one closed line, passed from the scanner to the frame tracker.
   typedef struct packed {
      logic                 numeric;
      logic [WORD_BITS-1:0] words;
      logic                 file_end;
   } line_type;

   // Sorts one byte into its character class.
   function automatic char_class_type classify(input logic [BYTE_BITS-1:0] c);
      char_class_type cls;
      if (c inside {[CHAR_ZERO:CHAR_NINE], CHAR_MINUS, CHAR_PLUS, CHAR_POINT,
                    CHAR_LOWER_E, CHAR_UPPER_E}) begin
         cls = CLASS_NUMERIC;
      end else if (c inside {[CHAR_BS:CHAR_CR], CHAR_SPACE}) begin
         cls = CLASS_WHITE;
      end else begin
         cls = CLASS_OTHER;
      end
      return cls;
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/ntls_scan.sv -----
`default_nettype none

module ntls_scan
   import ntls_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 step,
   input  wire logic [BYTE_BITS-1:0] data_byte,
   input  wire logic                 end_of_input,
   output logic                      line_done,
   output line_type                  line
);

   logic                 inside_word_ff, inside_word_in;
   logic                 saw_other_ff, saw_other_in;
   logic [WORD_BITS-1:0] words_ff, words_in;
   char_class_type       cls;

   // A line closes at a newline or at end of input.
   assign line_done = end_of_input || (data_byte == CHAR_NEWLINE);
   assign cls       = classify(data_byte);

   // Summary of the line that this request closes.
   assign line.numeric  = (words_ff != '0) && !saw_other_ff;
   assign line.words    = words_ff;
   assign line.file_end = end_of_input;

   // Word and class tracking within the current line.
   always_comb begin
      inside_word_in = inside_word_ff;
      saw_other_in   = saw_other_ff;
      words_in       = words_ff;
      if (line_done) begin
         inside_word_in = 1'b0;
         saw_other_in   = 1'b0;
         words_in       = '0;
      end else if (cls == CLASS_WHITE) begin
         inside_word_in = 1'b0;
      end else begin
         if (cls == CLASS_OTHER) begin
            saw_other_in = 1'b1;
         end
         if (!inside_word_ff) begin
            inside_word_in = 1'b1;
            if (words_ff != WORD_MAX) begin
               words_in = words_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inside_word_ff <= 1'b0;
         saw_other_ff   <= 1'b0;
         words_ff       <= '0;
      end else if (step) begin
         inside_word_ff <= inside_word_in;
         saw_other_ff   <= saw_other_in;
         words_ff       <= words_in;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/ntls_frame.sv -----
`default_nettype none

module ntls_frame
   import ntls_pkg::*;
#(
   parameter int FRAME_INDEX_BITS = FRAME_INDEX_BITS_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  step,
   input  line_type                   line,
   output frame_event_type            frame_event,
   output logic [FNUM_BITS-1:0]       frame_number,
   output logic [ROW_BITS-1:0]        frame_row,
   output logic [WORD_BITS-1:0]       frame_width
);

   logic                        prev_numeric_ff, prev_numeric_in;
   logic [WORD_BITS-1:0]        cols_ff, cols_in;
   logic [ROW_BITS-1:0]         rows_ff, rows_in;
   logic [FRAME_INDEX_BITS-1:0] frame_ff, frame_in;
   logic                        open_frame;

   // A numeric line opens a frame after a non-numeric line or on a width change.
   assign open_frame = line.numeric && (!prev_numeric_ff || (line.words != cols_ff));

   always_comb begin
      frame_event = EVENT_NONE;
      if (line.numeric) begin
         if (!prev_numeric_ff) begin
            frame_event = EVENT_TITLED;
         end else if (line.words != cols_ff) begin
            frame_event = EVENT_UNTITLED;
         end
      end
   end

   // Next frame state; the result reports the updated values.
   always_comb begin
      frame_in = frame_ff;
      rows_in  = rows_ff;
      cols_in  = cols_ff;
      if (open_frame) begin
         frame_in = frame_ff + 1'b1;
         rows_in  = ROW_BITS'(1);
         cols_in  = line.words;
      end else if (line.numeric && (rows_ff != ROW_MAX)) begin
         rows_in = rows_ff + 1'b1;
      end
      prev_numeric_in = line.file_end ? 1'b0 : line.numeric;
   end

   assign frame_number = FNUM_BITS'(frame_in);
   assign frame_row    = rows_in;
   assign frame_width  = cols_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_numeric_ff <= 1'b0;
         cols_ff         <= '0;
         rows_ff         <= '0;
         frame_ff        <= '0;
      end else if (step) begin
         prev_numeric_ff <= prev_numeric_in;
         cols_ff         <= cols_in;
         rows_ff         <= rows_in;
         frame_ff        <= frame_in;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/numeric_table_line_segmenter.sv -----
// A request is registered in the input register at acceptance; its result then goes to the result register.
// Throughput: one request per cycle; the input register and the result register decouple
// the two sides, so a request is taken while a result waits on rsp_tready, unless the
// registered request closes a line and must wait for the result register to free up.
// Only newline and end-of-input requests produce a result.
// Reset is synchronous and active high; it clears all line and frame state.
`default_nettype none

module numeric_table_line_segmenter
   import ntls_pkg::*;
#(
   parameter int FRAME_INDEX_BITS = FRAME_INDEX_BITS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] data_byte
   input  wire logic        req_tlast,   // end_of_input
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [47:0]      rsp_tdata,   // [7:0] word_count, [23:8] frame_number,
                                         // [39:24] frame_row, [47:40] frame_width
   output logic [2:0]       rsp_tuser,   // [0] line_numeric, [2:1] frame_event
   output logic             rsp_tlast    // file_ended
);

   logic                 in_valid_ff, in_valid_in;
   logic [BYTE_BITS-1:0] in_byte_ff;
   logic                 in_last_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 req_accept;
   logic                 stage_go;
   logic                 line_done;
   line_type             line;
   frame_event_type      frame_event;
   logic [FNUM_BITS-1:0] frame_number;
   logic [ROW_BITS-1:0]  frame_row;
   logic [WORD_BITS-1:0] frame_width;

   logic [47:0]          rsp_data_ff;
   logic [2:0]           rsp_user_ff;
   logic                 rsp_last_ff;

   // The registered request moves on unless it closes a line and the result is held.
   assign stage_go   = in_valid_ff && (!line_done || !rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || stage_go;
   assign req_accept = req_tvalid && req_tready;

   assign in_valid_in  = req_accept || (in_valid_ff && !stage_go);
   assign rsp_valid_in = (stage_go && line_done) || (rsp_valid_ff && !rsp_tready);

   ntls_scan u_scan (
      .clock        (clock),
      .reset        (reset),
      .step         (stage_go),
      .data_byte    (in_byte_ff),
      .end_of_input (in_last_ff),
      .line_done    (line_done),
      .line         (line)
   );

   ntls_frame #(
      .FRAME_INDEX_BITS (FRAME_INDEX_BITS)
   ) u_frame (
      .clock        (clock),
      .reset        (reset),
      .step         (stage_go && line_done),
      .line         (line),
      .frame_event  (frame_event),
      .frame_number (frame_number),
      .frame_row    (frame_row),
      .frame_width  (frame_width)
   );

   // Handshake control.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Input request register.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (stage_go && line_done) begin
         rsp_data_ff <= {frame_width, frame_row, frame_number, line.words};
         rsp_user_ff <= {frame_event, line.numeric};
         rsp_last_ff <= line.file_end;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTH
   // Only a numeric line can open a frame.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_user_ff[2:1] != EVENT_NONE) |-> rsp_user_ff[0])
      else $error("frame event reported for a non-numeric line");

   // A numeric line always belongs to a frame of its own width with at least one row.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_user_ff[0] |->
         (rsp_data_ff[39:24] != '0) && (rsp_data_ff[47:40] == rsp_data_ff[7:0]))
      else $error("numeric line does not match its frame");

   // A newly opened frame starts at its first row.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_user_ff[2:1] != EVENT_NONE) |-> (rsp_data_ff[39:24] == 16'd1))
      else $error("new frame does not start at row one");

   // A result is loaded only when a line-closing request leaves the input register.
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !line_done |=> !$rose(rsp_valid_ff))
      else $error("result produced without a closed line");
`endif

endmodule

`default_nettype wire
